// ----- design/fwtlv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwtlv_pkg
// types, codes and constants shared by the tlv firmware image section parser
// ----------------------------------------------------------------------------
package fwtlv_pkg;

    localparam logic [31:0] MAGIC_WORD  = 32'h0a4c5749;
    localparam logic [31:0] SEP_CPU     = 32'hFFFFCCCC;
    localparam logic [31:0] SEP_PAGING  = 32'hAAAABBBB;
    localparam logic [31:0] TYPE_RT     = 32'd19;
    localparam logic [31:0] TYPE_INIT   = 32'd20;

    // header byte positions
    localparam logic [31:0] HDR_TYPE_POS  = 32'd3;
    localparam logic [31:0] HDR_LEN_POS   = 32'd7;
    localparam logic [31:0] HDR_MAJOR_POS = 32'd75;
    localparam logic [31:0] HDR_BUILD_POS = 32'd79;
    localparam logic [31:0] HDR_LAST_POS  = 32'd87;
    localparam logic [31:0] HDR_BYTES     = 32'd88;

    // record header offsets relative to record start
    localparam logic [31:0] REC_TYPE_REL = 32'd3;
    localparam logic [31:0] REC_LEN_REL  = 32'd7;
    localparam logic [31:0] REC_OFF_REL  = 32'd11;
    localparam logic [31:0] REC_HDR_LEN  = 32'd8;
    localparam logic [31:0] REC_DATA_OFS = 32'd12;
    localparam logic [31:0] SEC_OFF_LEN  = 32'd4;

    // result kinds
    localparam logic [2:0] KIND_HDR_OK    = 3'd0;
    localparam logic [2:0] KIND_KEPT      = 3'd1;
    localparam logic [2:0] KIND_DROPPED   = 3'd2;
    localparam logic [2:0] KIND_SHORT     = 3'd3;
    localparam logic [2:0] KIND_OVERRUN   = 3'd4;
    localparam logic [2:0] KIND_BAD_HDR   = 3'd5;
    localparam logic [2:0] KIND_SUMMARY   = 3'd6;

    // separator markers
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_CPU    = 2'd1;
    localparam logic [1:0] MARK_PAGING = 2'd2;

    // configuration register indexes
    localparam logic CFG_IMAGE_SIZE    = 1'b0;
    localparam logic CFG_SECTION_LIMIT = 1'b1;

    localparam logic [31:0] IMAGE_SIZE_RST    = 32'd1;
    localparam logic [9:0]  SECTION_LIMIT_RST = 10'd32;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_RECHDR  = 6'b000010,
        PH_SECOFF  = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_STOPPED = 6'b010000,
        PH_ENDED   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic        is_init;
        logic [1:0]  marker;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] value_c;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

// ----- design/fwtlv_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwtlv_byte_if
// valid/ready channel carrying one firmware image byte per request
// ----------------------------------------------------------------------------
interface fwtlv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- design/fwtlv_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwtlv_result_if
// valid/ready channel carrying one parser result per request
// ----------------------------------------------------------------------------
interface fwtlv_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        is_init;
    logic [1:0]  marker;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic        last;

    modport source (output valid, output kind, output is_init, output marker,
                    output value_a, output value_b, output value_c, output last,
                    input ready);
    modport sink (input valid, input kind, input is_init, input marker,
                  input value_a, input value_b, input value_c, input last,
                  output ready);
endinterface
`default_nettype wire

// ----- design/firmware_tlv_section_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// firmware_tlv_section_parser_core
// streaming parser for a tlv firmware image: checks the header, walks the
// type/length records and reports sections, errors and a final summary
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake        payload
//  i_byte     in    valid / ready    data_byte[7:0]
//  o_result   out   valid / ready    kind, is_init, marker, value_a/b/c, last
//  cfg        in    i_cfg_we         i_cfg_idx (0 image_size, 1 section_limit),
//                                    i_cfg_data[31:0]
//
//  one image byte is taken per cycle while i_byte.ready is high; all parser
//  state updates at the edge that takes the byte, and its results (at most
//  two) enter a 4-entry result queue in that same edge
//  the result queue drains one request per cycle while o_result.ready is high;
//  i_byte.ready drops only while fewer than two queue slots are free
//  reset (synchronous, i_rst_n low) returns the parser to the header phase,
//  empties the queue and loads the register reset values
//
module firmware_tlv_section_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fwtlv_byte_if.sink       i_byte,
    fwtlv_result_if.source   o_result,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0] r_image_size;
    logic [9:0]  r_section_limit;

    // parser state
    fwtlv_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_word, n_word;
    logic [31:0] r_rtype, n_rtype;
    logic [31:0] r_rlen, n_rlen;
    logic [31:0] r_pleft, n_pleft;
    logic [31:0] r_rstart, n_rstart;
    logic [9:0]  r_kept, n_kept;
    logic [31:0] r_rcount, n_rcount;
    logic [31:0] r_vmajor, n_vmajor;
    logic [31:0] r_build, n_build;

    // result queue
    fwtlv_pkg::t_result r_q [fwtlv_pkg::Q_DEPTH];
    logic [fwtlv_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [fwtlv_pkg::Q_CW-1:0] r_count;

    // per-byte decode
    logic        in_fire;
    logic        out_fire;
    logic        active;
    logic        is_last;
    logic [31:0] w;
    logic [31:0] rel;
    logic        is_sec;
    logic [33:0] rec_end;
    logic        ev_v;
    logic        sm_v;
    fwtlv_pkg::t_result ev;
    fwtlv_pkg::t_result sm;
    fwtlv_pkg::t_result push0;
    fwtlv_pkg::t_result push1;
    logic [1:0]  n_push;
    logic [31:0] trail;

    // queue has room for the worst case of two results
    assign i_byte.ready = (r_count <= fwtlv_pkg::Q_CW'(fwtlv_pkg::Q_DEPTH - 2));
    assign in_fire      = i_byte.valid & i_byte.ready;
    assign out_fire     = o_result.valid & o_result.ready;

    // bytes at or past the image end, or after the stream has ended, are dropped
    assign active  = (r_phase != fwtlv_pkg::PH_ENDED) && (r_pos < r_image_size);
    assign is_last = ({1'b0, r_pos} + 33'd1) == {1'b0, r_image_size};
    // little-endian word: newest byte enters at the top
    assign w       = {i_byte.data_byte, r_word[31:8]};
    assign rel     = r_pos - r_rstart;
    assign is_sec  = (r_rtype == fwtlv_pkg::TYPE_RT) || (r_rtype == fwtlv_pkg::TYPE_INIT);
    assign rec_end = {2'b00, r_rstart} + 34'(fwtlv_pkg::REC_HDR_LEN) + {2'b00, w};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_word   = r_word;
        n_rtype  = r_rtype;
        n_rlen   = r_rlen;
        n_pleft  = r_pleft;
        n_rstart = r_rstart;
        n_kept   = r_kept;
        n_rcount = r_rcount;
        n_vmajor = r_vmajor;
        n_build  = r_build;
        ev_v     = 1'b0;
        ev       = '0;
        sm_v     = 1'b0;
        sm       = '0;
        trail    = '0;

        if (in_fire && active) begin
            n_word = w;
            if (r_pos != 32'hFFFFFFFF) begin
                n_pos = r_pos + 32'd1;
            end

            case (r_phase)
                fwtlv_pkg::PH_HEADER: begin
                    if (r_pos == fwtlv_pkg::HDR_TYPE_POS)  n_rtype  = w;
                    if (r_pos == fwtlv_pkg::HDR_LEN_POS)   n_rlen   = w;
                    if (r_pos == fwtlv_pkg::HDR_MAJOR_POS) n_vmajor = w;
                    if (r_pos == fwtlv_pkg::HDR_BUILD_POS) n_build  = w;
                    if (r_pos == fwtlv_pkg::HDR_LAST_POS) begin
                        ev_v = 1'b1;
                        if (r_rtype == 32'd0 && r_rlen == fwtlv_pkg::MAGIC_WORD) begin
                            ev.kind    = fwtlv_pkg::KIND_HDR_OK;
                            ev.value_a = r_vmajor;
                            ev.value_b = r_build;
                            n_rstart   = fwtlv_pkg::HDR_BYTES;
                            n_phase    = fwtlv_pkg::PH_RECHDR;
                        end else begin
                            ev.kind = fwtlv_pkg::KIND_BAD_HDR;
                            n_phase = fwtlv_pkg::PH_ENDED;
                        end
                    end else if (is_last) begin
                        // image ends inside the header
                        ev_v    = 1'b1;
                        ev.kind = fwtlv_pkg::KIND_BAD_HDR;
                        n_phase = fwtlv_pkg::PH_ENDED;
                    end
                end
                fwtlv_pkg::PH_RECHDR: begin
                    if (rel == fwtlv_pkg::REC_TYPE_REL) n_rtype = w;
                    if (rel == fwtlv_pkg::REC_LEN_REL) begin
                        n_rlen = w;
                        if (rec_end > {2'b00, r_image_size}) begin
                            ev_v       = 1'b1;
                            ev.kind    = fwtlv_pkg::KIND_OVERRUN;
                            ev.value_a = r_rstart;
                            n_phase    = fwtlv_pkg::PH_STOPPED;
                        end else begin
                            n_rcount = r_rcount + 32'd1;
                            n_pleft  = w;
                            if (is_sec && w >= fwtlv_pkg::SEC_OFF_LEN) begin
                                n_phase = fwtlv_pkg::PH_SECOFF;
                            end else begin
                                if (is_sec) begin
                                    // section too short for its offset word
                                    ev_v       = 1'b1;
                                    ev.kind    = fwtlv_pkg::KIND_SHORT;
                                    ev.is_init = (r_rtype == fwtlv_pkg::TYPE_INIT);
                                end
                                if (w == 32'd0) begin
                                    n_rstart = r_rstart + fwtlv_pkg::REC_HDR_LEN;
                                    n_phase  = fwtlv_pkg::PH_RECHDR;
                                end else begin
                                    n_phase = fwtlv_pkg::PH_SKIP;
                                end
                            end
                        end
                    end
                end
                fwtlv_pkg::PH_SECOFF: begin
                    n_pleft = r_pleft - 32'd1;
                    if (rel == fwtlv_pkg::REC_OFF_REL) begin
                        ev_v       = 1'b1;
                        ev.is_init = (r_rtype == fwtlv_pkg::TYPE_INIT);
                        if (w == fwtlv_pkg::SEP_CPU) begin
                            ev.marker = fwtlv_pkg::MARK_CPU;
                        end else if (w == fwtlv_pkg::SEP_PAGING) begin
                            ev.marker = fwtlv_pkg::MARK_PAGING;
                        end else begin
                            ev.marker = fwtlv_pkg::MARK_NONE;
                        end
                        if (r_kept < r_section_limit) begin
                            ev.kind = fwtlv_pkg::KIND_KEPT;
                            n_kept  = r_kept + 10'd1;
                        end else begin
                            ev.kind = fwtlv_pkg::KIND_DROPPED;
                        end
                        ev.value_a = w;
                        ev.value_b = r_rlen - fwtlv_pkg::SEC_OFF_LEN;
                        ev.value_c = r_rstart + fwtlv_pkg::REC_DATA_OFS;
                        if (n_pleft == 32'd0) begin
                            n_rstart = r_rstart + fwtlv_pkg::REC_HDR_LEN + r_rlen;
                            n_phase  = fwtlv_pkg::PH_RECHDR;
                        end else begin
                            n_phase = fwtlv_pkg::PH_SKIP;
                        end
                    end
                end
                fwtlv_pkg::PH_SKIP: begin
                    n_pleft = r_pleft - 32'd1;
                    if (n_pleft == 32'd0) begin
                        n_rstart = r_rstart + fwtlv_pkg::REC_HDR_LEN + r_rlen;
                        n_phase  = fwtlv_pkg::PH_RECHDR;
                    end
                end
                default: begin
                end
            endcase

            // summary on the final image byte
            if (is_last && n_phase != fwtlv_pkg::PH_ENDED) begin
                trail = r_image_size - n_rstart;
                if (n_phase == fwtlv_pkg::PH_STOPPED) begin
                    trail = trail - fwtlv_pkg::REC_HDR_LEN;
                end
                sm_v       = 1'b1;
                sm.kind    = fwtlv_pkg::KIND_SUMMARY;
                sm.value_a = n_rcount;
                sm.value_b = {22'd0, n_kept};
                sm.value_c = trail;
                n_phase    = fwtlv_pkg::PH_ENDED;
            end
        end
    end

    // order the results of this byte and flag the final one
    always_comb begin
        push0 = '0;
        push1 = '0;
        n_push = 2'd0;
        if (ev_v && sm_v) begin
            push0      = ev;
            push1      = sm;
            push1.last = 1'b1;
            n_push     = 2'd2;
        end else if (ev_v) begin
            push0      = ev;
            push0.last = 1'b1;
            n_push     = 2'd1;
        end else if (sm_v) begin
            push0      = sm;
            push0.last = 1'b1;
            n_push     = 2'd1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size    <= fwtlv_pkg::IMAGE_SIZE_RST;
            r_section_limit <= fwtlv_pkg::SECTION_LIMIT_RST;
            r_phase         <= fwtlv_pkg::PH_HEADER;
            r_pos           <= '0;
            r_word          <= '0;
            r_rtype         <= '0;
            r_rlen          <= '0;
            r_pleft         <= '0;
            r_rstart        <= '0;
            r_kept          <= '0;
            r_rcount        <= '0;
            r_vmajor        <= '0;
            r_build         <= '0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fwtlv_pkg::CFG_IMAGE_SIZE:    r_image_size    <= i_cfg_data;
                    fwtlv_pkg::CFG_SECTION_LIMIT: r_section_limit <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_word   <= n_word;
            r_rtype  <= n_rtype;
            r_rlen   <= n_rlen;
            r_pleft  <= n_pleft;
            r_rstart <= n_rstart;
            r_kept   <= n_kept;
            r_rcount <= n_rcount;
            r_vmajor <= n_vmajor;
            r_build  <= n_build;
            r_wr_ptr <= r_wr_ptr + fwtlv_pkg::Q_AW'(n_push);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + fwtlv_pkg::Q_AW'(1);
            end
            r_count <= r_count + fwtlv_pkg::Q_CW'(n_push)
                       - fwtlv_pkg::Q_CW'(out_fire);
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q[r_wr_ptr] <= push0;
        end
        if (n_push == 2'd2) begin
            r_q[r_wr_ptr + fwtlv_pkg::Q_AW'(1)] <= push1;
        end
    end

    assign o_result.valid   = (r_count != '0);
    assign o_result.kind    = r_q[r_rd_ptr].kind;
    assign o_result.is_init = r_q[r_rd_ptr].is_init;
    assign o_result.marker  = r_q[r_rd_ptr].marker;
    assign o_result.value_a = r_q[r_rd_ptr].value_a;
    assign o_result.value_b = r_q[r_rd_ptr].value_b;
    assign o_result.value_c = r_q[r_rd_ptr].value_c;
    assign o_result.last    = r_q[r_rd_ptr].last;

`ifndef NO_ASSERTIONS
    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fwtlv_pkg::Q_CW'(fwtlv_pkg::Q_DEPTH))
        else $error("result queue overflow");

    // once the stream has ended the parser stays ended
    a_ended_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fwtlv_pkg::PH_ENDED) |=> (r_phase == fwtlv_pkg::PH_ENDED))
        else $error("parser left the ended phase");

    // two results from one byte only when the second is the summary
    a_pair_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push == 2'd2) |-> (push1.kind == fwtlv_pkg::KIND_SUMMARY && push1.last))
        else $error("second result of a byte is not the summary");

    // a summary always moves the parser to the ended phase
    a_summary_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sm_v |=> (r_phase == fwtlv_pkg::PH_ENDED))
        else $error("summary without ending the stream");
`endif

endmodule
`default_nettype wire
